FILE: src/packet_filter_first_match_assert.svh
// ----------------------------------------------------------------------------
// Packet filter assertion macros
// Concurrent checks on the clock and reset of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef PACKET_FILTER_FIRST_MATCH_ASSERT_SVH
`define PACKET_FILTER_FIRST_MATCH_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PF_ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);
// Implication checked in the cycle after the condition.
`define PF_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);
`endif

FILE: src/pff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter package
// Shared constants and types of the first-match packet filter.
// ----------------------------------------------------------------------------
package pff_pkg;
   localparam int RULE_ENTRIES   = 16;
   localparam int PORTS_PER_RULE = 10;
   localparam int IDX_W  = 4;
   localparam int SLOT_W = 4;

   localparam logic [2:0] OP_CHECK    = 3'd0;
   localparam logic [2:0] OP_WR_ADDR  = 3'd1;
   localparam logic [2:0] OP_WR_ATTR  = 3'd2;
   localparam logic [2:0] OP_WR_PORT  = 3'd3;
   localparam logic [2:0] OP_RD_CNT   = 3'd4;

   localparam logic [1:0] KIND_ALL  = 2'd0;
   localparam logic [1:0] KIND_TCP  = 2'd1;
   localparam logic [1:0] KIND_UDP  = 2'd2;
   localparam logic [1:0] KIND_ICMP = 2'd3;

   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [7:0] PROTO_ICMP = 8'd1;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_RULES  = 1'b1;

   // Broadcast from the controller to every rule cell.
   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  rule_index;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] source_mask;
      logic [31:0] dest_mask;
      logic [1:0]  pkind;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] total_length;
      logic [13:0] rule_attributes;
      logic [3:0]  port_slot;
      logic        attr_ok;
   } cmd_type;

   // Per-cell controls issued in the commit cycle.
   typedef struct packed {
      logic        wr;
      logic        bump;
   } cell_ctl_type;
endpackage

FILE: src/pff_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter channels
// Valid/ready interfaces for request, response and register writes.
// ----------------------------------------------------------------------------
interface pff_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [3:0]  rule_index;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [31:0] source_mask;
   logic [31:0] dest_mask;
   logic [7:0]  protocol;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [15:0] total_length;
   logic [13:0] rule_attributes;
   logic [3:0]  port_slot;
   modport source (output valid, opcode, rule_index, src_addr, dst_addr, source_mask,
                   dest_mask, protocol, source_port, dest_port, total_length,
                   rule_attributes, port_slot, input ready);
   modport sink (input valid, opcode, rule_index, src_addr, dst_addr, source_mask,
                 dest_mask, protocol, source_port, dest_port, total_length,
                 rule_attributes, port_slot, output ready);
endinterface

interface pff_rsp_if;
   logic        valid;
   logic        ready;
   logic        verdict;
   logic        rule_hit;
   logic [3:0]  hit_index;
   logic [31:0] packet_count;
   logic [31:0] byte_count;
   logic        status;
   modport source (output valid, verdict, rule_hit, hit_index, packet_count, byte_count,
                   status, input ready);
   modport sink (input valid, verdict, rule_hit, hit_index, packet_count, byte_count,
                 status, output ready);
endinterface

interface pff_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [4:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/packet_filter_first_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match packet filter
// Ordered rule table of cells with per-rule hit counters.
// ----------------------------------------------------------------------------
// Every word passes through three steps. At the accepting edge the request is
// latched and broadcast to the row of rule cells. In the next cycle each cell
// compares it against its own rule and registers a match bit. In the cycle
// after that the first-match chain running through the cells picks the
// winner, its counters are updated and the response is loaded into the
// output register, where it is held until taken. A new word is accepted only
// in the idle state, which is entered once the previous response is taken,
// so a new word cannot be accepted before the last response has been taken.
// Rule contents are undefined until written; counters clear at reset and on
// every accepted attribute write. Register writes take effect at once and
// belong in periods when no word is in flight.
// ----------------------------------------------------------------------------
module packet_filter_first_match
   import pff_pkg::*;
(
   input logic clock,
   input logic reset,
   pff_req_if.sink   req,
   pff_rsp_if.source rsp,
   pff_csr_if.sink   csr
);
`include "packet_filter_first_match_assert.svh"
   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_EVAL, S_OUT} state_type;
   state_type   state_ff;
   cmd_type     cmd_ff;
   logic        policy_ff;
   logic [4:0]  rules_ff;
   logic        verdict_ff, hit_ff, status_ff;
   logic [3:0]  hidx_ff;
   logic [31:0] pc_ff, bc_ff;
   logic        verdict_in, hit_in, status_in;
   logic [3:0]  hidx_in;
   logic [31:0] pc_in, bc_in;

   logic [RULE_ENTRIES:0] chain;
   logic [RULE_ENTRIES-1:0] match, acc, first;
   logic [31:0] pcnt [RULE_ENTRIES];
   logic [31:0] bcnt [RULE_ENTRIES];
   cell_ctl_type ctl [RULE_ENTRIES];
   logic [1:0] pkind_in;
   logic [3:0] ns_in, nd_in;
   logic attr_ok_in;

   assign chain[0] = 1'b0;
   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE);

   // Protocol numbers other than tcp, udp and icmp only meet rules of kind all.
   always_comb begin
      unique case (req.protocol)
         PROTO_TCP:  pkind_in = KIND_TCP;
         PROTO_UDP:  pkind_in = KIND_UDP;
         PROTO_ICMP: pkind_in = KIND_ICMP;
         default:    pkind_in = KIND_ALL;
      endcase
   end
   // An attribute write is refused when a range needs two ports it lacks or
   // when both lists together overflow the port slots.
   assign ns_in = req.rule_attributes[8:5];
   assign nd_in = req.rule_attributes[13:10];
   assign attr_ok_in = !((req.rule_attributes[3] && ns_in < 4'd2)
                         || (req.rule_attributes[4] && nd_in < 4'd2)
                         || (5'(ns_in) + 5'(nd_in) > 5'(PORTS_PER_RULE)));

   // The cells register their match bits during S_MATCH; in S_EVAL the chain
   // marks the lowest matching index as the only first match.
   for (genvar g = 0; g < RULE_ENTRIES; g++) begin : g_cell
      assign first[g] = match[g] && !chain[g];
      assign ctl[g].wr = (state_ff == S_EVAL) && cmd_ff.rule_index == IDX_W'(g);
      assign ctl[g].bump = (state_ff == S_EVAL) && cmd_ff.opcode == OP_CHECK && first[g];
      pff_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd_ff),
         .enabled((rules_ff > 5'(g)) && cmd_ff.opcode == OP_CHECK), .ctl(ctl[g]),
         .hit_prev(chain[g]), .hit_next(chain[g+1]), .match_ff(match[g]),
         .accept(acc[g]), .pkt_cnt(pcnt[g]), .byte_cnt(bcnt[g]));
   end

   // Response word for the command held in cmd_ff; every field not set by
   // the opcode reads as zero.
   always_comb begin
      verdict_in = 1'b0;
      hit_in     = 1'b0;
      hidx_in    = '0;
      pc_in      = '0;
      bc_in      = '0;
      status_in  = 1'b0;
      unique case (cmd_ff.opcode)
         OP_CHECK: begin
            verdict_in = chain[RULE_ENTRIES] ? |(first & acc) : policy_ff;
            hit_in = chain[RULE_ENTRIES];
            for (int i = 0; i < RULE_ENTRIES; i++)
               if (first[i]) hidx_in = IDX_W'(i);
         end
         OP_WR_ATTR: status_in = !cmd_ff.attr_ok;
         OP_RD_CNT: begin
            pc_in = pcnt[cmd_ff.rule_index];
            bc_in = bcnt[cmd_ff.rule_index];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         policy_ff <= 1'b1;
         rules_ff  <= '0;
      end else begin
         if (csr.valid) begin
            if (csr.index == CSR_POLICY) policy_ff <= csr.data[0];
            else rules_ff <= csr.data;
         end
         unique case (state_ff)
            S_IDLE: if (req.valid) begin
               cmd_ff <= '{req.opcode, req.rule_index, req.src_addr, req.dst_addr,
                           req.source_mask, req.dest_mask, pkind_in, req.source_port,
                           req.dest_port, req.total_length, req.rule_attributes,
                           req.port_slot, attr_ok_in};
               state_ff <= S_MATCH;
            end
            S_MATCH: state_ff <= S_EVAL;
            S_EVAL: begin
               verdict_ff <= verdict_in;
               hit_ff     <= hit_in;
               hidx_ff    <= hidx_in;
               pc_ff      <= pc_in;
               bc_ff      <= bc_in;
               status_ff  <= status_in;
               state_ff   <= S_OUT;
            end
            S_OUT: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.verdict = verdict_ff;
   assign rsp.rule_hit = hit_ff;
   assign rsp.hit_index = hidx_ff;
   assign rsp.packet_count = pc_ff;
   assign rsp.byte_count = bc_ff;
   assign rsp.status = status_ff;

   `PF_ASSERT_NEXT(a_match_to_eval, state_ff == S_MATCH, state_ff == S_EVAL, "match overran")
   `PF_ASSERT_NEXT(a_eval_to_out, state_ff == S_EVAL, state_ff == S_OUT, "eval overran")
   `PF_ASSERT_IMPLY(a_one_winner, state_ff == S_EVAL, $onehot0(first), "two first matches")
   `PF_ASSERT_IMPLY(a_no_accept_busy, state_ff != S_IDLE, !req.ready, "accept while busy")
endmodule

FILE: src/pff_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter rule cell
// Holds one rule and its counters, matches the broadcast packet, and
// passes the first-match chain to its neighbor.
// ----------------------------------------------------------------------------
module pff_cell
   import pff_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  logic         enabled,
   input  cell_ctl_type ctl,
   input  logic         hit_prev,
   output logic         hit_next,
   output logic         match_ff,
   output logic         accept,
   output logic [31:0]  pkt_cnt,
   output logic [31:0]  byte_cnt
);
   logic [31:0] src_ff, dst_ff, smask_ff, dmask_ff;
   logic [13:0] attr_ff;
   logic [15:0] port_ff [PORTS_PER_RULE];
   logic [31:0] pkt_ff, byte_ff;
   logic        match_in;
   logic [1:0]  kind;
   logic [3:0]  ns, nd;
   logic        sacc, dacc;

   assign kind = attr_ff[1:0];
   assign ns   = attr_ff[8:5];
   assign nd   = attr_ff[13:10];

   always_comb begin
      logic [4:0] k;
      sacc = (ns == 4'd0);
      dacc = (nd == 4'd0);
      for (int i = 0; i < PORTS_PER_RULE; i++) begin
         k = 5'(i);
         if (k < {1'b0, ns}) begin
            if (attr_ff[3] && ns >= 4'd2 && k < 5'd2) begin
               if (k == 5'd0 && port_ff[0] <= cmd.source_port
                   && cmd.source_port <= port_ff[1])
                  sacc = 1'b1;
            end else if (port_ff[i] == cmd.source_port) begin
               sacc = 1'b1;
            end
         end else if (k < 5'(ns) + 5'(nd)) begin
            if (attr_ff[4] && nd >= 4'd2 && k < 5'(ns) + 5'd2) begin
               if (k == 5'(ns) && port_ff[i] <= cmd.dest_port && (i + 1 < PORTS_PER_RULE)
                   && cmd.dest_port <= port_ff[(i + 1) % PORTS_PER_RULE])
                  dacc = 1'b1;
            end else if (port_ff[i] == cmd.dest_port) begin
               dacc = 1'b1;
            end
         end
      end
   end

   always_comb begin
      match_in = enabled && ((cmd.src_addr & smask_ff) == src_ff)
                 && ((cmd.dst_addr & dmask_ff) == dst_ff);
      if (kind != KIND_ALL) begin
         if (kind != cmd.pkind) match_in = 1'b0;
         else if (kind != KIND_ICMP)
            match_in = match_in && (5'(ns) + 5'(nd) <= 5'(PORTS_PER_RULE)) && sacc && dacc;
      end
   end

   assign hit_next = hit_prev | match_ff;
   assign accept   = attr_ff[2];
   assign pkt_cnt  = pkt_ff;
   assign byte_cnt = byte_ff;

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      if (ctl.wr && cmd.opcode == OP_WR_ADDR) begin
         src_ff <= cmd.src_addr; dst_ff <= cmd.dst_addr;
         smask_ff <= cmd.source_mask; dmask_ff <= cmd.dest_mask;
      end
      if (ctl.wr && cmd.opcode == OP_WR_ATTR && cmd.attr_ok) attr_ff <= cmd.rule_attributes;
      for (int i = 0; i < PORTS_PER_RULE; i++)
         if (ctl.wr && cmd.opcode == OP_WR_PORT && cmd.port_slot == SLOT_W'(i))
            port_ff[i] <= cmd.source_port;
      if (reset || (ctl.wr && cmd.opcode == OP_WR_ATTR && cmd.attr_ok)) begin
         pkt_ff <= '0; byte_ff <= '0;
      end else if (ctl.bump) begin
         pkt_ff <= pkt_ff + 32'd1;
         byte_ff <= byte_ff + 32'(cmd.total_length);
      end
   end
endmodule
